FILE: hdl/fir_q15_valid_filter_defines.svh
// Assertion macros for the Q15 valid-mode FIR filter.
// Included by the top level only; no dependencies.
`ifndef FIR_Q15_VALID_FILTER_DEFINES_SVH
`define FIR_Q15_VALID_FILTER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define FQV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqv assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define FQV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqv assertion failed");

`endif

FILE: hdl/fqv_pkg.sv
// Shared types and constants for the Q15 valid-mode FIR filter.
// No dependencies; used by every module of the block.
package fqv_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W    = 16;
    localparam int TAP_CNT_W   = 6;
    localparam int COEF_ADDR_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int FRAC_BITS   = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_DATA    = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_OUT
    } t_state;

    // Control broadcast to every cell of the delay line.
    typedef struct packed {
        logic load;  // input transfer: shift delay line, reload work copy
        logic step;  // work copy moves one cell toward cell zero
    } t_cell_ctrl;

endpackage

FILE: hdl/fqv_cell.sv
// One delay-line cell: a stored sample and a work copy for the MAC sweep.
// Depends on fqv_pkg.
module fqv_cell (
    input  logic                                i_clk,
    input  fqv_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [fqv_pkg::SAMPLE_W-1:0] i_tap,
    input  logic signed [fqv_pkg::SAMPLE_W-1:0] i_work,
    output logic signed [fqv_pkg::SAMPLE_W-1:0] o_tap,
    output logic signed [fqv_pkg::SAMPLE_W-1:0] o_work
);

    logic signed [fqv_pkg::SAMPLE_W-1:0] r_tap;
    logic signed [fqv_pkg::SAMPLE_W-1:0] r_work;

    // The sample moves up one cell per transfer; the work copy starts equal to
    // the new sample and then moves down one cell per MAC step.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_tap  <= i_tap;
            r_work <= i_tap;
        end else if (i_ctrl.step) begin
            r_work <= i_work;
        end
    end

    assign o_tap  = r_tap;
    assign o_work = r_work;

endmodule

FILE: hdl/fqv_coef_mem.sv
// Coefficient store: one write port, one registered read port, valid bits.
// Depends on fqv_pkg.
module fqv_coef_mem #(
    parameter int DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic signed [fqv_pkg::SAMPLE_W-1:0] i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic signed [fqv_pkg::SAMPLE_W-1:0] o_rdata
);

    logic signed [fqv_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]                    r_valid;
    logic signed [fqv_pkg::SAMPLE_W-1:0] r_rdata;
    logic                                r_rvalid;

    // Storage array and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // Valid bits make never-written entries read as zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

FILE: hdl/fqv_mac.sv
// Multiply-accumulate unit with floor shift and int16 saturation.
// Depends on fqv_pkg.
module fqv_mac #(
    parameter int MAX_TAPS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic                                i_issue,
    input  logic signed [fqv_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [fqv_pkg::SAMPLE_W-1:0] i_coef,
    output logic                                o_busy,
    output logic signed [fqv_pkg::SAMPLE_W-1:0] o_result
);

    localparam int ACC_W = fqv_pkg::PROD_W + ((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0) + 1;
    localparam int Q_W   = ACC_W - fqv_pkg::FRAC_BITS;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

    logic                                r_v1;
    logic                                r_v2;
    logic signed [fqv_pkg::SAMPLE_W-1:0] r_samp;
    logic signed [fqv_pkg::PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]             r_acc;
    logic signed [Q_W-1:0]               q;

    // Stage valids follow the sample through read, multiply and add.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
        end
    end

    // Sample is registered alongside the registered coefficient read.
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_samp <= i_sample;
        end
        r_prod <= r_samp * i_coef;
    end

    // Exact accumulation of the products of one item.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Arithmetic shift right (floor) and saturation to int16.
    always_comb begin
        q = r_acc[ACC_W-1:fqv_pkg::FRAC_BITS];
        if (q > Q_MAX) begin
            o_result = 16'sh7FFF;
        end else if (q < Q_MIN) begin
            o_result = -16'sh8000;
        end else begin
            o_result = q[fqv_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_busy = r_v1 || r_v2;

endmodule

FILE: hdl/fir_q15_valid_filter.sv
// Q15 valid-mode FIR filter. An input transfer that completes a window starts
// the MAC sweep over the T effective taps, one tap per cycle; the sequencer then
// drains the MAC pipeline and loads the output register. Input stays stalled
// until the output register can take the result; an item without a result leaves
// the input ready. Synchronous active-low reset clears the fill count, the control
// registers and the coefficient valid bits, so the store reads zero.
`include "fir_q15_valid_filter_defines.svh"

module fir_q15_valid_filter #(
    parameter int MAX_TAPS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [fqv_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                                   i_block_start,
    // Output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [fqv_pkg::SAMPLE_W-1:0]    o_filtered,
    // Configuration port
    input  logic                                   i_cfg_we,
    input  logic [fqv_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [fqv_pkg::SAMPLE_W-1:0]           i_cfg_data
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FW = $clog2(MAX_TAPS + 1);

    fqv_pkg::t_state     r_state;
    fqv_pkg::t_state     n_state;
    fqv_pkg::t_cell_ctrl cell_ctrl;

    logic [fqv_pkg::TAP_CNT_W-1:0]   r_num_taps;
    logic [fqv_pkg::COEF_ADDR_W-1:0] r_coef_address;
    logic [FW-1:0]                   r_fill;
    logic [FW-1:0]                   fill_base;
    logic [FW-1:0]                   n_fill;
    logic [AW-1:0]                   r_cidx;
    logic                            r_out_valid;
    logic signed [fqv_pkg::SAMPLE_W-1:0] r_out;

    logic        in_accept;
    logic        emit;
    logic        out_free;
    logic        run_step;
    logic        out_load;
    logic        mac_busy;
    logic        coef_we;
    int unsigned tap_ext;
    int unsigned t_eff;
    logic [31:0] addr_ext;

    logic signed [fqv_pkg::SAMPLE_W-1:0] taps  [MAX_TAPS];
    logic signed [fqv_pkg::SAMPLE_W-1:0] works [MAX_TAPS];
    logic signed [fqv_pkg::SAMPLE_W-1:0] coef;
    logic signed [fqv_pkg::SAMPLE_W-1:0] mac_result;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Configuration registers; a coefficient write goes to the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_taps     <= fqv_pkg::TAP_CNT_W'(1);
            r_coef_address <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fqv_pkg::CFG_NUM_TAPS: begin
                    r_num_taps <= i_cfg_data[fqv_pkg::TAP_CNT_W-1:0];
                end
                fqv_pkg::CFG_COEF_ADDRESS: begin
                    r_coef_address <= i_cfg_data[fqv_pkg::COEF_ADDR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign addr_ext = 32'(r_coef_address);
    assign coef_we  = i_cfg_we && (i_cfg_index == fqv_pkg::CFG_COEF_DATA)
                      && (addr_ext < 32'(MAX_TAPS));

    // Effective tap count and fill count of the current block.
    always_comb begin
        tap_ext = 32'(r_num_taps);
        if (tap_ext == 0) begin
            t_eff = 1;
        end else if (tap_ext > 32'(MAX_TAPS)) begin
            t_eff = 32'(MAX_TAPS);
        end else begin
            t_eff = tap_ext;
        end
        fill_base = i_block_start ? '0 : r_fill;
        if (32'(fill_base) < 32'(MAX_TAPS)) begin
            n_fill = fill_base + FW'(1);
        end else begin
            n_fill = fill_base;
        end
        emit = 32'(n_fill) >= t_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (in_accept) begin
            r_fill <= n_fill;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fqv_pkg::S_IDLE: begin
                if (in_accept && emit) begin
                    n_state = fqv_pkg::S_RUN;
                end
            end
            fqv_pkg::S_RUN: begin
                if (r_cidx == '0) begin
                    n_state = fqv_pkg::S_DRAIN;
                end
            end
            fqv_pkg::S_DRAIN: begin
                if (!mac_busy) begin
                    n_state = fqv_pkg::S_OUT;
                end
            end
            fqv_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = fqv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fqv_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = 1'b1;
        run_step   = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            fqv_pkg::S_IDLE:  o_in_stall = 1'b0;
            fqv_pkg::S_RUN:   run_step   = 1'b1;
            fqv_pkg::S_DRAIN: begin
            end
            fqv_pkg::S_OUT:   out_load   = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fqv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Coefficient index counts down from the newest-sample weight to zero.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cidx <= AW'(t_eff - 1);
        end else if (run_step) begin
            r_cidx <= r_cidx - AW'(1);
        end
    end

    // Delay line as a chain of cells.
    assign cell_ctrl.load = in_accept;
    assign cell_ctrl.step = run_step;

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        logic signed [fqv_pkg::SAMPLE_W-1:0] tap_in;
        logic signed [fqv_pkg::SAMPLE_W-1:0] work_in;

        if (g == 0) begin : g_head
            assign tap_in = i_sample;
        end else begin : g_body
            assign tap_in = taps[g-1];
        end

        if (g == MAX_TAPS - 1) begin : g_tail
            assign work_in = '0;
        end else begin : g_link
            assign work_in = works[g+1];
        end

        fqv_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (cell_ctrl),
            .i_tap  (tap_in),
            .i_work (work_in),
            .o_tap  (taps[g]),
            .o_work (works[g])
        );
    end

    fqv_coef_mem #(
        .DEPTH (MAX_TAPS)
    ) u_coef_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (coef_we),
        .i_waddr (addr_ext[AW-1:0]),
        .i_wdata (i_cfg_data),
        .i_raddr (r_cidx),
        .o_rdata (coef)
    );

    fqv_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (in_accept),
        .i_issue  (run_step),
        .i_sample (works[0]),
        .i_coef   (coef),
        .o_busy   (mac_busy),
        .o_result (mac_result)
    );

    // Output register keeps the result while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= mac_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out;

    // A new result only appears after the sequencer reached the output state.
    `FQV_ASSERT_NOW(a_out_from_seq, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == fqv_pkg::S_OUT))
    // The sweep ends after the weight of the oldest sample.
    `FQV_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, (r_state == fqv_pkg::S_RUN) && (r_cidx == '0), r_state == fqv_pkg::S_DRAIN)
    // A sample that completes no window starts no MAC sweep.
    `FQV_ASSERT_NEXT(a_no_result_idle, i_clk, i_rst_n, in_accept && !emit, (r_state == fqv_pkg::S_IDLE) && !mac_busy)
    // The MAC pipeline is empty whenever new samples are taken.
    `FQV_ASSERT_NOW(a_mac_idle_on_accept, i_clk, i_rst_n, in_accept, !mac_busy)

endmodule
